// ===== src/xml_entity_escaper_macros.svh =====
// Assertion macros shared by the escaper RTL.
`ifndef XML_ENTITY_ESCAPER_MACROS_SVH
`define XML_ENTITY_ESCAPER_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define XEE_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same check, also active while reset is high.
`define XEE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/xee_pkg.sv =====
// Types, constants and entity tables for the XML entity escaper.
`default_nettype none
package xee_pkg;

   localparam int BYTE_W     = 8;
   localparam int IDX_W      = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BYTE_W-1:0] CHAR_LT   = 8'h3C;
   localparam logic [BYTE_W-1:0] CHAR_GT   = 8'h3E;
   localparam logic [BYTE_W-1:0] CHAR_AMP  = 8'h26;
   localparam logic [BYTE_W-1:0] CHAR_APOS = 8'h27;
   localparam logic [BYTE_W-1:0] CHAR_QUOT = 8'h22;

   // Register index of exempt_char in the word-address space.
   localparam logic CSR_IDX_EXEMPT = 1'b0;

   typedef enum logic [2:0] {
      KIND_PLAIN = 3'd0,
      KIND_LT    = 3'd1,
      KIND_GT    = 3'd2,
      KIND_AMP   = 3'd3,
      KIND_APOS  = 3'd4,
      KIND_QUOT  = 3'd5
   } kind_type;

   function automatic kind_type classify(input logic [BYTE_W-1:0] b,
                                         input logic [BYTE_W-1:0] exempt);
      kind_type k;
      k = KIND_PLAIN;
      if (b != exempt) begin
         priority case (b)
            CHAR_LT:   k = KIND_LT;
            CHAR_GT:   k = KIND_GT;
            CHAR_AMP:  k = KIND_AMP;
            CHAR_APOS: k = KIND_APOS;
            CHAR_QUOT: k = KIND_QUOT;
            default:   k = KIND_PLAIN;
         endcase
      end
      return k;
   endfunction

   // Index of the final byte of the run for each kind.
   function automatic logic [IDX_W-1:0] last_idx(input kind_type k);
      logic [IDX_W-1:0] n;
      unique case (k)
         KIND_PLAIN: n = 3'd0;
         KIND_LT:    n = 3'd3;
         KIND_GT:    n = 3'd3;
         KIND_AMP:   n = 3'd4;
         KIND_APOS:  n = 3'd5;
         KIND_QUOT:  n = 3'd5;
         default:    n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] ent_char(input kind_type k,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = b;
      if (k != KIND_PLAIN) begin
         if (idx == 3'd0) begin
            c = CHAR_AMP;
         end else begin
            unique case (k)
               KIND_LT:   c = (idx == 3'd1) ? "l" : (idx == 3'd2) ? "t" : ";";
               KIND_GT:   c = (idx == 3'd1) ? "g" : (idx == 3'd2) ? "t" : ";";
               KIND_AMP:  c = (idx == 3'd1) ? "a" : (idx == 3'd2) ? "m" :
                              (idx == 3'd3) ? "p" : ";";
               KIND_APOS: c = (idx == 3'd1) ? "a" : (idx == 3'd2) ? "p" :
                              (idx == 3'd3) ? "o" : (idx == 3'd4) ? "s" : ";";
               KIND_QUOT: c = (idx == 3'd1) ? "q" : (idx == 3'd2) ? "u" :
                              (idx == 3'd3) ? "o" : (idx == 3'd4) ? "t" : ";";
               default:   c = b;
            endcase
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== src/xml_entity_escaper.sv =====
// A taken word passes the item register, then the output register onto rsp; stalls hold it.
// Throughput: one input word per cycle for plain bytes while rsp_tready allows; an entity
// holds req_tready low until its last byte loads into the one-byte-per-cycle output register.
// Output register and item register allow a new word in while a result waits.
// Synchronous active-high reset clears both valid flags and exempt_char to zero.
// No memory, no clearing pass.
`default_nettype none
`include "xml_entity_escaper_macros.svh"
module xml_entity_escaper
   import xee_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [BYTE_W-1:0]     req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tlast,   // string_last
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [BYTE_W-1:0]     rsp_tdata,   // [7:0] out_byte
   output      logic                  rsp_tlast,   // run_last
   output      logic [0:0]            rsp_tuser,   // [0] string_end
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   logic [BYTE_W-1:0] exempt_ff, exempt_in;

   logic              item_valid_ff, item_valid_in;
   logic [BYTE_W-1:0] item_byte_ff, item_byte_in;
   logic              item_last_ff, item_last_in;
   kind_type          item_kind_ff, item_kind_in;
   logic [IDX_W-1:0]  item_idx_ff, item_idx_in;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_end_ff, out_end_in;

   logic out_load, item_final, item_done, req_take, csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_EXEMPT)
                       ? {{(CSR_DATA_W-BYTE_W){1'b0}}, exempt_ff} : '0;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign item_final = (item_idx_ff == last_idx(item_kind_ff));
   assign item_done  = item_valid_ff && out_load && item_final;
   assign req_tready = !item_valid_ff || item_done;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      exempt_in = exempt_ff;
      if (csr_write && csr_paddr[2] == CSR_IDX_EXEMPT) begin
         exempt_in = csr_pwdata[BYTE_W-1:0];
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      item_byte_in  = item_byte_ff;
      item_last_in  = item_last_ff;
      item_kind_in  = item_kind_ff;
      item_idx_in   = item_idx_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
         item_byte_in  = req_tdata;
         item_last_in  = req_tlast;
         item_kind_in  = classify(req_tdata, exempt_ff);
         item_idx_in   = '0;
      end else if (item_done) begin
         item_valid_in = 1'b0;
      end else if (item_valid_ff && out_load) begin
         item_idx_in = item_idx_ff + 3'd1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      if (out_load) begin
         out_valid_in = item_valid_ff;
         out_byte_in  = ent_char(item_kind_ff, item_idx_ff, item_byte_ff);
         out_last_in  = item_final;
         out_end_in   = item_final && item_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exempt_ff     <= '0;
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         exempt_ff     <= exempt_in;
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_byte_ff <= item_byte_in;
      item_last_ff <= item_last_in;
      item_kind_ff <= item_kind_in;
      item_idx_ff  <= item_idx_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_byte_ff;
   assign rsp_tlast    = out_last_ff;
   assign rsp_tuser[0] = out_end_ff;

   `XEE_ASSERT_CLK(a_end_on_last, rsp_tvalid && rsp_tuser[0] |-> rsp_tlast, "string end off run end")
   `XEE_ASSERT_CLK(a_idx_in_run, item_valid_ff |-> item_idx_ff <= last_idx(item_kind_ff), "index past run")
   `XEE_ASSERT_CLK(a_item_held, item_valid_ff && !item_done |=> item_valid_ff, "item dropped early")
   `XEE_ASSERT_CLK(a_take_loads, req_tvalid && req_tready |=> item_valid_ff && item_idx_ff == 3'd0, "word not loaded")
   `XEE_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_tvalid && req_tready, "reset left state")

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for the XML entity escaper: directed table, random phases, stream checker.
`default_nettype none
module tb_top;
   import xee_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 9;
   localparam int TAIL_CYCLES    = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_WORDS    = 55;

   localparam logic [CSR_ADDR_W-1:0] ADDR_EXEMPT   = CSR_ADDR_W'(4 * CSR_IDX_EXEMPT);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = ADDR_EXEMPT + CSR_ADDR_W'(4);

   localparam logic [BYTE_W-1:0] SPECIALS [5] = '{CHAR_LT, CHAR_GT, CHAR_AMP, CHAR_APOS,
                                                 CHAR_QUOT};

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] value;
      logic [BYTE_W-1:0]     data;
      logic                  last;
      logic                  typed;
      logic [BYTE_W-1:0]     typed_byte;
   } dir_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              string_end;
   } escaped_type;

   localparam int NUM_ROWS = 27;
   localparam dir_row_type DIRECTED [NUM_ROWS] = '{
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         8'h00,     1'b0, 1'b1, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         8'hFF,     1'b1, 1'b1, 8'hFF},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_LT,   1'b0, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_GT,   1'b1, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_AMP,  1'b0, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_APOS, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_QUOT, 1'b1, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         8'h41,     1'b1, 1'b1, 8'h41},
      '{ROW_CSR,  ADDR_EXEMPT,   32'h22,        8'h00,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_QUOT, 1'b0, 1'b1, CHAR_QUOT},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_APOS, 1'b1, 1'b0, 8'h00},
      '{ROW_CSR,  ADDR_EXEMPT,   32'h27,        8'h00,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_APOS, 1'b0, 1'b1, CHAR_APOS},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_QUOT, 1'b1, 1'b0, 8'h00},
      '{ROW_CSR,  ADDR_EXEMPT,   32'hFFFF_FF3C, 8'h00,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_LT,   1'b1, 1'b1, CHAR_LT},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_GT,   1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  ADDR_EXEMPT,   32'h26,        8'h00,     1'b0, 1'b0, 8'h00},
      '{ROW_CSR,  ADDR_UNMAPPED, 32'h0,         8'h00,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_AMP,  1'b1, 1'b1, CHAR_AMP},
      '{ROW_CSR,  ADDR_EXEMPT,   32'hFF,        8'h00,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         8'hFF,     1'b0, 1'b1, 8'hFF},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_LT,   1'b1, 1'b0, 8'h00},
      '{ROW_CSR,  ADDR_EXEMPT,   32'h0,         8'h00,     1'b0, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         8'h00,     1'b1, 1'b1, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         CHAR_AMP,  1'b1, 1'b0, 8'h00},
      '{ROW_WORD, ADDR_EXEMPT,   32'h0,         8'h80,     1'b0, 1'b1, 8'h80}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;   // [7:0] data_byte
   logic                  req_tlast;   // string_last
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BYTE_W-1:0]     rsp_tdata;   // [7:0] out_byte
   logic                  rsp_tlast;   // run_last
   logic [0:0]            rsp_tuser;   // [0] string_end
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic              req_typed;
   logic [BYTE_W-1:0] req_typed_byte;

   escaped_type       escaped_q [$];
   logic [BYTE_W-1:0] exempt_model;
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   int                burst_left = 0;
   bit                no_gaps = 1'b0;
   logic [8:0]        stall_cyc = '0;

   xml_entity_escaper DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Queue the escaped run for one input byte under the current exemption.
   function automatic void predict_escape(input logic [BYTE_W-1:0] b, input logic last);
      string ent;
      ent = "";
      if (b != exempt_model) begin
         case (b)
            CHAR_LT:   ent = "&lt;";
            CHAR_GT:   ent = "&gt;";
            CHAR_AMP:  ent = "&amp;";
            CHAR_APOS: ent = "&apos;";
            CHAR_QUOT: ent = "&quot;";
            default:   ent = "";
         endcase
      end
      if (ent.len() == 0) begin
         escaped_q.push_back('{b, 1'b1, last});
      end else begin
         for (int i = 0; i < ent.len(); i++) begin
            escaped_q.push_back('{ent[i], i == ent.len() - 1, (i == ent.len() - 1) && last});
         end
      end
   endfunction

   task automatic send_word(input logic [BYTE_W-1:0] b, input logic last, input logic typed,
                            input logic [BYTE_W-1:0] typed_byte);
      int gap;
      if (burst_left == 0) begin
         gap = no_gaps ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid     <= 1'b1;
      req_tdata      <= b;
      req_tlast      <= last;
      req_typed      <= typed;
      req_typed_byte <= typed_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (escaped_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Receiver: cycle through always-ready, random, periodic and heavy stall stretches.
   always @(posedge clock) begin
      stall_cyc <= stall_cyc + 1'b1;
      case (stall_cyc[8:7])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(0, 2) != 0);
         2'd2:    rsp_tready <= (stall_cyc[2:0] < 3'd3);
         default: rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin
      escaped_type want;
      if (reset) begin
         exempt_model = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == ADDR_EXEMPT) begin
            exempt_model = csr_pwdata[BYTE_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (escaped_q.size() == 0) begin
               $error("unexpected word: out_byte %02h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = escaped_q.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.run_last) begin
                  $error("run_last: expected %0b, got %0b", want.run_last, rsp_tlast);
                  mismatch_count++;
               end
               if (rsp_tuser[0] !== want.string_end) begin
                  $error("string_end: expected %0b, got %0b", want.string_end, rsp_tuser[0]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_typed) begin
               escaped_q.push_back('{req_typed_byte, 1'b1, req_tlast});
            end else begin
               predict_escape(req_tdata, req_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [BYTE_W-1:0]     b;
      logic [BYTE_W-1:0]     ex;
      logic [CSR_DATA_W-1:0] v;
      int                    sel;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      req_typed      = 1'b0;
      req_typed_byte = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         if (DIRECTED[r].kind == ROW_CSR) begin
            wait_drained();
            csr_write(DIRECTED[r].addr, DIRECTED[r].value);
         end else begin
            send_word(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].typed,
                      DIRECTED[r].typed_byte);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       ex = 8'h00;
            1:       ex = 8'hFF;
            2:       ex = CHAR_QUOT;
            3:       ex = CHAR_APOS;
            4:       ex = SPECIALS[$urandom_range(0, 4)];
            default: ex = BYTE_W'($urandom_range(0, 255));
         endcase
         v = $urandom;
         v[BYTE_W-1:0] = ex;
         wait_drained();
         csr_write(ADDR_EXEMPT, v);
         no_gaps = (phase % 3 == 1);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
               b = SPECIALS[$urandom_range(0, 4)];
            end else if (sel == 4) begin
               b = ex;
            end else begin
               b = BYTE_W'($urandom_range(0, 255));
            end
            send_word(b, $urandom_range(0, 3) == 0, 1'b0, 8'h00);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
